[sv/gss_pkg.sv]
`default_nettype none

package gss_pkg;

  // Golden factor 0.618033988749895 as an unsigned Q0.32 constant
  localparam logic [31:0] GOLD_Q32 = 32'd2654435769;
  localparam logic [31:0] ROUND_HALF_Q32 = 32'h8000_0000;

  // Input transaction kinds (in_tuser bit 0)
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_VALUE = 1'b1;

  // Configuration register indexes
  localparam logic REG_TOLERANCE  = 1'b0;
  localparam logic REG_ITER_LIMIT = 1'b1;

  localparam int TOL_W   = 31;
  localparam int LIMIT_W = 8;

  localparam logic [TOL_W-1:0]   TOL_RESET   = 31'd66;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd100;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_FIRST  = 4'b0010,
    PH_SECOND = 4'b0100,
    PH_STEP   = 4'b1000
  } phase_t;

endpackage

`default_nettype wire

[sv/golden_section_minimizer.sv]
`default_nettype none

// Channel  Dir  Fields (lowest bit first)
// in_      in   tdata: lower_bound, upper_bound, func_value; tuser: action, value_is_nan
// out_     out  tdata: point; tuser: is_final
// cfg_     in   index 0 tolerance (31 b), index 1 iteration_limit (8 b)
//
// Every input transaction yields exactly one result transaction, registered in
// the cycle after acceptance. A new transaction is accepted every cycle while
// in_tready is high; the path from the search state through two constant
// golden-ratio multipliers, the value compare and the probe select sets the
// clock. in_tready drops only while a result is held and out_tready is low.
// Synchronous reset on rst_n low clears the search state and loads register defaults.

module golden_section_minimizer
  import gss_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int COUNT_WIDTH = 8
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire logic                                         in_tvalid,
  output logic                                              in_tready,
  // lower_bound, upper_bound, func_value
  input  wire logic [((3*COORD_WIDTH+7)/8)*8-1:0]           in_tdata,
  // action, value_is_nan
  input  wire logic [1:0]                                   in_tuser,
  output logic                                              out_tvalid,
  input  wire logic                                         out_tready,
  // point
  output logic [((COORD_WIDTH+7)/8)*8-1:0]                  out_tdata,
  // is_final
  output logic                                              out_tuser,
  input  wire logic                                         cfg_wr_en,
  input  wire logic                                         cfg_addr,
  input  wire logic [TOL_W-1:0]                             cfg_wdata
);

  localparam int W       = COORD_WIDTH;
  localparam int OUT_W   = ((COORD_WIDTH + 7) / 8) * 8;
  localparam int CMP_W   = ((W + 1 > TOL_W + 2) ? W + 1 : TOL_W + 2) + 1;
  localparam int LIM_W   = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
  localparam logic signed [W-1:0] LARGEST = {1'b0, {(W-1){1'b1}}};

  // Configuration registers
  logic [TOL_W-1:0]   tol_r;
  logic [LIMIT_W-1:0] lim_r;

  // Search state
  logic signed [W-1:0] lo_r, lo_nxt;
  logic signed [W-1:0] hi_r, hi_nxt;
  logic signed [W-1:0] il_r, il_nxt;
  logic signed [W-1:0] ih_r, ih_nxt;
  logic signed [W-1:0] best_r, best_nxt;
  logic                kept_r, kept_nxt;
  logic [COUNT_WIDTH-1:0] step_r, step_nxt;
  phase_t              phase_r, phase_nxt;

  // Result register
  logic                out_valid_r;
  logic signed [W-1:0] point_r, point_nxt;
  logic                final_r, final_nxt;

  // Unpacked input fields
  logic                in_fire;
  logic                action;
  logic                is_nan;
  logic signed [W-1:0] lower_bound, upper_bound, func_value, value;

  // Datapath
  logic signed [W-1:0] mul_a_lo, mul_a_hi;
  logic signed [W:0]   off_a, off_b;
  logic signed [W-1:0] fa, fb;
  logic                take_low;
  logic signed [W-1:0] lo_c, hi_c, surv_c, probe_c;
  logic signed [W:0]   diff_c, sum_c, sum_cur;
  logic [COUNT_WIDTH-1:0] step_c;
  logic                cont_c;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign action      = in_tuser[0];
  assign is_nan      = in_tuser[1];
  assign lower_bound = $signed(in_tdata[W-1:0]);
  assign upper_bound = $signed(in_tdata[2*W-1:W]);
  assign func_value  = $signed(in_tdata[3*W-1:2*W]);
  assign value       = is_nan ? LARGEST : func_value;

  // Multiplier A serves the start bounds or the low-kept interval (lo, ih);
  // multiplier B serves the high-kept interval (il, hi).
  assign mul_a_lo = (action == ACT_START) ? lower_bound : lo_r;
  assign mul_a_hi = (action == ACT_START) ? upper_bound : ih_r;

  gss_gold_offset #(.COORD_WIDTH(W)) u_off_a (
    .lo_i  (mul_a_lo),
    .hi_i  (mul_a_hi),
    .off_o (off_a)
  );

  gss_gold_offset #(.COORD_WIDTH(W)) u_off_b (
    .lo_i  (il_r),
    .hi_i  (hi_r),
    .off_o (off_b)
  );

  always_comb begin
    // fa is the value at inner_low, fb at inner_high
    if (phase_r == PH_STEP && !kept_r) begin
      fa = value;
      fb = best_r;
    end else begin
      fa = best_r;
      fb = value;
    end
    take_low = fa < fb;

    lo_c   = take_low ? lo_r : il_r;
    hi_c   = take_low ? ih_r : hi_r;
    surv_c = take_low ? il_r : ih_r;
    probe_c = take_low ?
              W'($signed({ih_r[W-1], ih_r}) - off_a) :
              W'($signed({il_r[W-1], il_r}) + off_b);

    if (phase_r == PH_STEP && step_r != {COUNT_WIDTH{1'b1}}) begin
      step_c = step_r + 1'b1;
    end else begin
      step_c = step_r;
    end

    diff_c  = $signed({hi_c[W-1], hi_c}) - $signed({lo_c[W-1], lo_c});
    sum_c   = $signed({hi_c[W-1], hi_c}) + $signed({lo_c[W-1], lo_c});
    sum_cur = $signed({hi_r[W-1], hi_r}) + $signed({lo_r[W-1], lo_r});

    // Continue while under the step limit and half-width above tolerance
    cont_c = (LIM_W'(step_c) < LIM_W'(lim_r)) &&
             ($signed({{(CMP_W-W-1){diff_c[W]}}, diff_c}) >
              $signed({{(CMP_W-TOL_W-1){1'b0}}, tol_r, 1'b0}));
  end

  always_comb begin
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    il_nxt    = il_r;
    ih_nxt    = ih_r;
    best_nxt  = best_r;
    kept_nxt  = kept_r;
    step_nxt  = step_r;
    phase_nxt = phase_r;
    point_nxt = point_r;
    final_nxt = final_r;
    if (in_fire) begin
      if (action == ACT_START) begin
        // Drop any running search and issue the first probe
        lo_nxt    = lower_bound;
        hi_nxt    = upper_bound;
        il_nxt    = W'($signed({upper_bound[W-1], upper_bound}) - off_a);
        ih_nxt    = W'($signed({lower_bound[W-1], lower_bound}) + off_a);
        step_nxt  = '0;
        kept_nxt  = 1'b0;
        phase_nxt = PH_FIRST;
        point_nxt = W'($signed({upper_bound[W-1], upper_bound}) - off_a);
        final_nxt = 1'b0;
      end else begin
        unique case (phase_r)
          PH_FIRST: begin
            best_nxt  = value;
            phase_nxt = PH_SECOND;
            point_nxt = ih_r;
            final_nxt = 1'b0;
          end
          PH_SECOND, PH_STEP: begin
            lo_nxt   = lo_c;
            hi_nxt   = hi_c;
            best_nxt = take_low ? fa : fb;
            kept_nxt = !take_low;
            step_nxt = step_c;
            il_nxt   = surv_c;
            ih_nxt   = surv_c;
            if (cont_c) begin
              if (take_low) begin
                il_nxt = probe_c;
              end else begin
                ih_nxt = probe_c;
              end
              phase_nxt = PH_STEP;
              point_nxt = probe_c;
              final_nxt = 1'b0;
            end else begin
              phase_nxt = PH_IDLE;
              point_nxt = sum_c[W:1];
              final_nxt = 1'b1;
            end
          end
          default: begin
            // Value with no search running: report the stored midpoint
            point_nxt = sum_cur[W:1];
            final_nxt = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
      lim_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_TOLERANCE:  tol_r <= cfg_wdata;
        REG_ITER_LIMIT: lim_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r        <= '0;
      hi_r        <= '0;
      il_r        <= '0;
      ih_r        <= '0;
      best_r      <= '0;
      kept_r      <= 1'b0;
      step_r      <= '0;
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
      il_r    <= il_nxt;
      ih_r    <= ih_nxt;
      best_r  <= best_nxt;
      kept_r  <= kept_nxt;
      step_r  <= step_nxt;
      phase_r <= phase_nxt;
      // Hold the result until taken; refill on every accepted transaction
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    point_r <= point_nxt;
    final_r <= final_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'($unsigned(point_r));
  assign out_tuser  = final_r;

endmodule

`default_nettype wire

[sv/gss_gold_offset.sv]
`default_nettype none

module gss_gold_offset
  import gss_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic signed [COORD_WIDTH-1:0] lo_i,
  input  wire logic signed [COORD_WIDTH-1:0] hi_i,
  output logic signed [COORD_WIDTH:0]        off_o
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = DW + 32;

  logic signed [DW-1:0] diff;
  logic [DW-1:0]        mag;
  logic [PW-1:0]        prod;
  logic [DW-1:0]        rnd;

  // (hi - lo) * golden factor on the magnitude, rounded half away from zero
  always_comb begin
    diff  = $signed({hi_i[COORD_WIDTH-1], hi_i}) - $signed({lo_i[COORD_WIDTH-1], lo_i});
    mag   = diff[DW-1] ? (~diff + 1'b1) : diff;
    prod  = PW'(mag) * PW'(GOLD_Q32) + PW'(ROUND_HALF_Q32);
    rnd   = prod[PW-1:32];
    off_o = diff[DW-1] ? $signed(~rnd + 1'b1) : $signed(rnd);
  end

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench
  import gss_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int RAND_ITEMS = 1650;
  localparam int N_PHASES = 6;
  localparam int COUNT_MAX = 255;
  localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;

  // One result transaction: probe coordinate and the final-result flag
  typedef struct packed {
    logic [31:0] point;
    logic        fin;
  } probe_t;

  // Scoreboard: tracks the search state of the block, predicts the probe that
  // each accepted transaction asks for and checks results against the oldest
  // pending prediction.
  class gss_scoreboard;
    probe_t             probe_q[$];
    probe_t             last_req;
    logic [TOL_W-1:0]   tol;
    logic [LIMIT_W-1:0] lim;
    longint             ivl_lo;
    longint             ivl_hi;
    longint             inner_lo;
    longint             inner_hi;
    longint             best;
    bit                 kept_hi;
    int unsigned        steps;
    phase_t             ph;
    int unsigned        errors;
    int unsigned        n_final;

    function new();
      tol      = TOL_RESET;
      lim      = LIMIT_RESET;
      ivl_lo   = 0;
      ivl_hi   = 0;
      inner_lo = 0;
      inner_hi = 0;
      best     = 0;
      kept_hi  = 1'b0;
      steps    = 0;
      ph       = PH_IDLE;
      errors   = 0;
      n_final  = 0;
      last_req = '0;
    endfunction

    function void set_reg(logic idx, logic [TOL_W-1:0] val);
      if (idx == REG_TOLERANCE) begin
        tol = val;
      end else begin
        lim = val[LIMIT_W-1:0];
      end
    endfunction

    // (hi - lo) times the golden factor, rounded half away from zero
    function longint gold_offset(longint lo, longint hi);
      longint    diff;
      bit [63:0] mag;
      bit [63:0] low_part;
      bit [63:0] prod;
      diff = hi - lo;
      mag = (diff < 0) ? -diff : diff;
      low_part = ({32'd0, mag[31:0]} * {32'd0, GOLD_Q32} + {32'd0, ROUND_HALF_Q32}) >> 32;
      prod = {32'd0, mag[63:32]} * {32'd0, GOLD_Q32} + low_part;
      return (diff < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    function probe_t to_probe(longint p, bit fin);
      probe_t r;
      r.point = p[31:0];
      r.fin   = fin;
      return r;
    endfunction

    // Floor of the interval midpoint
    function longint mid_point();
      longint s;
      s = ivl_lo + ivl_hi;
      return s >>> 1;
    endfunction

    // Strict less-than keeps the low side; ties keep the high side
    function void keep_side(longint fa, longint fb);
      if (fa < fb) begin
        best     = fa;
        ivl_hi   = inner_hi;
        inner_hi = inner_lo;
        kept_hi  = 1'b0;
      end else begin
        best     = fb;
        ivl_lo   = inner_lo;
        inner_lo = inner_hi;
        kept_hi  = 1'b1;
      end
    endfunction

    function probe_t next_probe();
      longint diff;
      diff = ivl_hi - ivl_lo;
      if (steps < lim && diff > 2 * longint'(tol)) begin
        ph = PH_STEP;
        if (kept_hi) begin
          inner_hi = ivl_lo + gold_offset(ivl_lo, ivl_hi);
          return to_probe(inner_hi, 1'b0);
        end
        inner_lo = ivl_hi - gold_offset(ivl_lo, ivl_hi);
        return to_probe(inner_lo, 1'b0);
      end
      ph = PH_IDLE;
      return to_probe(mid_point(), 1'b1);
    endfunction

    function void note_item(logic act, int lo, int hi, int fv, logic nan);
      longint v;
      probe_t r;
      if (act == ACT_START) begin
        ivl_lo   = longint'(lo);
        ivl_hi   = longint'(hi);
        inner_lo = ivl_hi - gold_offset(ivl_lo, ivl_hi);
        inner_hi = ivl_lo + gold_offset(ivl_lo, ivl_hi);
        steps    = 0;
        kept_hi  = 1'b0;
        ph       = PH_FIRST;
        r        = to_probe(inner_lo, 1'b0);
      end else begin
        v = nan ? longint'(COORD_MAX) : longint'(fv);
        case (ph)
          PH_FIRST: begin
            best = v;
            ph   = PH_SECOND;
            r    = to_probe(inner_hi, 1'b0);
          end
          PH_SECOND: begin
            keep_side(best, v);
            r = next_probe();
          end
          PH_STEP: begin
            if (kept_hi) keep_side(best, v);
            else keep_side(v, best);
            if (steps < COUNT_MAX) steps++;
            r = next_probe();
          end
          default: r = to_probe(mid_point(), 1'b1);
        endcase
      end
      probe_q.push_back(r);
      last_req = r;
    endfunction

    function void check_probe(logic [31:0] pt, logic fin);
      probe_t e;
      if (probe_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: point=%h is_final=%b", pt, fin);
        return;
      end
      e = probe_q.pop_front();
      if (e.fin) n_final++;
      if (pt !== e.point || fin !== e.fin) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: point exp %h got %h, is_final exp %b got %b",
                   e.point, pt, e.fin, fin);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;    // lower_bound, upper_bound, func_value
  logic [1:0]  in_tuser;    // action, value_is_nan
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;   // point
  logic        out_tuser;   // is_final
  logic        cfg_wr_en;
  logic        cfg_addr;
  logic [TOL_W-1:0] cfg_wdata;

  gss_scoreboard sb = new();

  int unsigned cycles = 0;
  int unsigned n_items = 0;
  int unsigned n_starts = 0;
  int unsigned n_aborts = 0;
  int unsigned n_nan = 0;
  int unsigned n_writes = 0;
  bit          in_free = 1'b0;
  bit          out_free = 1'b0;
  int unsigned stall_left = 0;

  // Objective used to answer probe requests, chosen per search
  int unsigned obj_mode;
  int          obj_center;
  int          obj_base;
  int unsigned obj_shift;

  golden_section_minimizer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort the run if it hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, sb.probe_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // Result side back-pressure: mostly short stalls, a few long ones, and
  // stretches of free flow that toggle at random
  always @(negedge clk) begin
    if ($urandom_range(0, 999) == 0) out_free = !out_free;
    if (!out_free && stall_left == 0 && $urandom_range(0, 99) < 25)
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Check every result transaction at the edge that accepts it
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_probe(out_tdata, out_tuser);
  end

  function automatic int pick_gap();
    int unsigned r;
    if (in_free) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic int objective(int x);
    longint d;
    case (obj_mode)
      0: begin
        d = longint'(x) - longint'(obj_center);
        if (d < 0) d = -d;
        d = (d >>> obj_shift) + longint'(obj_base);
        if (d > COORD_MAX) d = COORD_MAX;
        return int'(d);
      end
      1: return $urandom();
      default: return obj_base;
    endcase
  endfunction

  // Present one transaction after a random gap and hold it until accepted
  task automatic send_item(logic act, int lo, int hi, int fv, logic nan);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {fv, hi, lo};
    in_tuser  = {nan, act};
    do @(posedge clk); while (!in_tready);
    sb.note_item(act, lo, hi, fv, nan);
    n_items++;
    if (act == ACT_VALUE && nan) n_nan++;
  endtask

  // Drop valid and wait until every predicted result has been checked
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.probe_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [TOL_W-1:0] val);
    @(negedge clk);
    in_tvalid = 1'b0;
    cfg_wr_en = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.set_reg(idx, val);
    n_writes++;
  endtask

  // One search: a start transaction, then the objective value at each
  // requested probe until the final midpoint comes back. Occasionally drop
  // the search half way (the next start restarts it) or poke the idle block.
  task automatic run_search();
    int          lo;
    int          hi;
    int          t;
    int unsigned r;
    longint      span;
    r  = $urandom_range(0, 99);
    lo = $urandom();
    hi = $urandom();
    if (r < 70) begin
      if (lo > hi) begin
        t  = lo;
        lo = hi;
        hi = t;
      end
    end else if (r < 78) begin
      hi = lo;
    end else if (r < 90) begin
      hi = lo + int'($urandom_range(0, 32'h0010_0000));
    end
    span = longint'(hi) - longint'(lo);
    if (span >= 0) obj_center = int'(longint'(lo) + longint'($urandom()) % (span + 1));
    else obj_center = $urandom();
    r = $urandom_range(0, 99);
    obj_mode  = (r < 60) ? 0 : (r < 85) ? 1 : 2;
    obj_shift = $urandom_range(0, 8);
    obj_base  = -int'($urandom_range(0, 32'h4000_0000));
    in_free   = ($urandom_range(0, 4) == 0);

    send_item(ACT_START, lo, hi, $urandom(), 1'($urandom_range(0, 1)));
    n_starts++;
    while (!sb.last_req.fin) begin
      if ($urandom_range(0, 99) == 0) begin
        n_aborts++;
        return;
      end
      send_item(ACT_VALUE, $urandom(), $urandom(), objective(sb.last_req.point),
                $urandom_range(0, 99) < 4);
    end
    if ($urandom_range(0, 9) == 0)
      send_item(ACT_VALUE, $urandom(), $urandom(), $urandom(), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int phase_end;
    int base_items;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_wr_en = 1'b0;
    cfg_addr  = REG_TOLERANCE;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, register defaults
    // value while idle right after reset: final midpoint of the cleared interval
    send_item(ACT_VALUE, 0, 0, 0, 1'b1);
    // widest interval, extreme values, NaN values
    send_item(ACT_START, COORD_MIN, COORD_MAX, 0, 1'b0);
    send_item(ACT_VALUE, 0, 0, COORD_MAX, 1'b0);
    send_item(ACT_VALUE, 0, 0, COORD_MIN, 1'b0);
    send_item(ACT_VALUE, 0, 0, 0, 1'b1);
    send_item(ACT_VALUE, 0, 0, 0, 1'b1);
    send_item(ACT_VALUE, 0, 0, -1, 1'b0);
    // start while a search runs; equal bounds and tied values end at once
    send_item(ACT_START, 32'sh0001_0000, 32'sh0001_0000, 0, 1'b0);
    send_item(ACT_VALUE, 0, 0, 5, 1'b0);
    send_item(ACT_VALUE, 0, 0, 5, 1'b0);
    // value while idle: midpoint of the stored interval
    send_item(ACT_VALUE, COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
    // reversed bounds, NaN against NaN (tie keeps the high side)
    send_item(ACT_START, 32'sh0064_0000, -32'sh0064_0000, 0, 1'b0);
    send_item(ACT_VALUE, 0, 0, 1, 1'b0);
    send_item(ACT_VALUE, 0, 0, 2, 1'b0);
    send_item(ACT_START, COORD_MAX, COORD_MIN, COORD_MIN, 1'b1);
    send_item(ACT_VALUE, 0, 0, 0, 1'b1);
    send_item(ACT_VALUE, 0, 0, COORD_MIN, 1'b1);
    send_item(ACT_VALUE, 0, 0, 0, 1'b0);
    // iteration limit zero: final right after the two opening values
    drain();
    write_reg(REG_ITER_LIMIT, TOL_W'(0));
    send_item(ACT_START, 0, 32'sh0010_0000, 0, 1'b0);
    send_item(ACT_VALUE, 0, 0, 3, 1'b0);
    send_item(ACT_VALUE, 0, 0, 2, 1'b0);
    send_item(ACT_VALUE, 0, 0, 7, 1'b0);

    // Random part, one register setting per phase, extremes first
    base_items = n_items;
    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      case (p)
        0: begin
          write_reg(REG_TOLERANCE, '0);
          write_reg(REG_ITER_LIMIT, TOL_W'(COUNT_MAX));
        end
        1: begin
          write_reg(REG_TOLERANCE, {TOL_W{1'b1}});
          write_reg(REG_ITER_LIMIT, '0);
        end
        2: begin
          write_reg(REG_TOLERANCE, TOL_W'($urandom_range(0, 32'h0001_0000)));
          write_reg(REG_ITER_LIMIT, TOL_W'($urandom_range(1, 60)));
        end
        3: begin
          write_reg(REG_TOLERANCE, TOL_RESET);
          write_reg(REG_ITER_LIMIT, TOL_W'(LIMIT_RESET));
        end
        4: begin
          write_reg(REG_TOLERANCE, TOL_W'($urandom()));
          write_reg(REG_ITER_LIMIT, TOL_W'($urandom_range(0, COUNT_MAX)));
        end
        default: begin
          write_reg(REG_TOLERANCE, TOL_W'($urandom_range(0, 255)));
          write_reg(REG_ITER_LIMIT, TOL_W'(COUNT_MAX));
        end
      endcase
      phase_end = base_items + (p + 1) * RAND_ITEMS / N_PHASES;
      while (n_items < phase_end) run_search();
    end

    // Wait out the tail, then report
    drain();
    repeat (10) @(posedge clk);
    $display("run covered %0d transactions: %0d searches (%0d dropped midway), %0d NaN values",
             n_items, n_starts, n_aborts, n_nan);
    $display("%0d final results, %0d register writes, %0d cycles",
             sb.n_final, n_writes, cycles);
    if (sb.errors == 0 && sb.probe_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results never seen", sb.errors, sb.probe_q.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/gss_pkg.sv
sv/gss_gold_offset.sv
sv/golden_section_minimizer.sv
test/testbench.sv
